[rtl/core/matrix_keypad_scanner_macros.svh]
// ---------------------------------------------------------------------------
// Keypad scanner assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define KPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keypad scanner check failed");
// next-cycle implication, checked out of reset
`define KPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keypad scanner check failed");
`else
`define KPD_ASSERT_NOW(label, clk, rst, ante, cons)
`define KPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/kpd_pkg.sv]
// ---------------------------------------------------------------------------
// Keypad scanner package
// Shared types, command codes, the number key table and the letter base.
// ---------------------------------------------------------------------------
package kpd_pkg;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_TOGGLE = 2'd1,
      CMD_SET    = 2'd2
   } cmd_type;

   typedef enum logic {
      CSR_DEBOUNCE    = 1'b0,
      CSR_INIT_LAYOUT = 1'b1
   } csr_index_type;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
   localparam logic        LAYOUT_RESET   = 1'b0;

   // result beat
   typedef struct packed {
      logic [3:0] row_drive;
      logic       key_valid;
      logic [6:0] key_code;
      logic       layout_now;
   } rsp_type;

   localparam logic [6:0] NUMBER_KEYS [16] = '{
      7'h37, 7'h38, 7'h39, 7'h2F,   // 7 8 9 /
      7'h34, 7'h35, 7'h36, 7'h2A,   // 4 5 6 *
      7'h31, 7'h32, 7'h33, 7'h2D,   // 1 2 3 -
      7'h23, 7'h30, 7'h3D, 7'h2B    // # 0 = +
   };

   localparam logic [6:0] LETTER_BASE = 7'h41;

   function automatic logic [6:0] key_of(input logic layout, input logic [1:0] row,
                                         input logic [1:0] col);
      logic [3:0] pos;
      pos = {row, col};
      if (layout) begin
         key_of = LETTER_BASE + {3'b000, pos};
      end else begin
         key_of = NUMBER_KEYS[pos];
      end
   endfunction

endpackage

[rtl/core/matrix_keypad_scanner.sv]
// ---------------------------------------------------------------------------
// Matrix keypad scanner (4x4)
// Result: a result beat is registered and appears the cycle after its command beat.
// Throughput: one command beat per cycle unless rsp_stall holds the result.
// Reset: synchronous; scan at row 0 column 0, layout numbers, debounce 20.
// ---------------------------------------------------------------------------
`include "matrix_keypad_scanner_macros.svh"

module matrix_keypad_scanner
   import kpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_column_levels,
   input  logic        req_layout_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_row_drive,
   output logic        rsp_key_valid,
   output logic [6:0]  rsp_key_code,
   output logic        rsp_layout_now,
   // register write port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] debounce_ff;
   logic        accept;
   logic        out_busy;
   rsp_type     step_result;
   rsp_type     out_data;

   // Debounce count register. The initial-layout register is write-only in
   // effect: reset always restores it to numbers before the layout loads, so
   // the scan core takes the reset constant directly and a write there is
   // accepted and dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_we && (csr_index == CSR_DEBOUNCE)) begin
         debounce_ff <= csr_wdata;
      end
   end

   // Accept a command beat whenever the result register is free or drains
   // in this same cycle.
   assign req_stall = out_busy;
   assign accept    = req_valid && !out_busy;

   // Scan state and one-pass step: state advances on every accepted beat.
   kpd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (accept),
      .cmd      (req_command),
      .cols     (req_column_levels),
      .lay      (req_layout_value),
      .debounce (debounce_ff),
      .result   (step_result)
   );

   // Result register parts the two channels.
   kpd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (step_result),
      .out_stall (rsp_stall),
      .busy      (out_busy),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_row_drive  = out_data.row_drive;
   assign rsp_key_valid  = out_data.key_valid;
   assign rsp_key_code   = out_data.key_code;
   assign rsp_layout_now = out_data.layout_now;

   // exactly one row driven low
   `KPD_ASSERT_NOW(a_one_row_low, clock, reset, rsp_valid, $onehot(~rsp_row_drive))
   // a released key always carries a printable code, idle beats carry zero
   `KPD_ASSERT_NOW(a_code_on_key, clock, reset, rsp_valid && rsp_key_valid,
                   rsp_key_code >= 7'h23)
   `KPD_ASSERT_NOW(a_code_idle, clock, reset, rsp_valid && !rsp_key_valid,
                   rsp_key_code == 7'd0)
   // an accepted beat always lands in the result register
   `KPD_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, rsp_valid)

endmodule

[rtl/core/kpd_core.sv]
// ---------------------------------------------------------------------------
// Keypad scanner core
// Scan state and the single-pass step logic for one command beat.
// ---------------------------------------------------------------------------
module kpd_core
   import kpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic [1:0]  cmd,
   input  logic [3:0]  cols,
   input  logic        lay,
   input  logic [15:0] debounce,
   output rsp_type     result
);

   logic        layout_ff, layout_in;
   logic [1:0]  row_ff, row_in;
   logic [1:0]  col_ff, col_in;
   logic        wait_ff, wait_in;
   logic [15:0] settle_ff, settle_in;
   logic [6:0]  held_ff, held_in;
   logic        col_high;
   logic        advance;
   logic        key_valid;

   assign col_high = cols[col_ff];

   always_comb begin
      layout_in = layout_ff;
      wait_in   = wait_ff;
      settle_in = settle_ff;
      held_in   = held_ff;
      advance   = 1'b0;
      key_valid = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (wait_ff) begin
               if (col_high) begin
                  key_valid = 1'b1;
                  wait_in   = 1'b0;
                  advance   = 1'b1;
               end
            end else if (settle_ff < debounce) begin
               settle_in = settle_ff + 16'd1;
            end else if (!col_high) begin
               held_in = key_of(layout_ff, row_ff, col_ff);
               wait_in = 1'b1;
            end else begin
               advance = 1'b1;
            end
         end
         CMD_TOGGLE: layout_in = ~layout_ff;
         CMD_SET:    layout_in = lay;
         default:    layout_in = layout_ff;
      endcase

      // step to the next column, wrapping into the next row
      row_in = row_ff;
      col_in = col_ff;
      if (advance) begin
         settle_in = '0;
         col_in    = col_ff + 2'd1;
         if (col_ff == 2'd3) begin
            row_in = row_ff + 2'd1;
         end
      end

      result.row_drive  = ~(4'b0001 << row_in);
      result.key_valid  = key_valid;
      result.key_code   = key_valid ? held_ff : 7'd0;
      result.layout_now = layout_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         wait_ff   <= 1'b0;
         settle_ff <= '0;
         held_ff   <= '0;
      end else if (step_en) begin
         layout_ff <= layout_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         wait_ff   <= wait_in;
         settle_ff <= settle_in;
         held_ff   <= held_in;
      end
   end

endmodule

[rtl/core/kpd_out_reg.sv]
// ---------------------------------------------------------------------------
// Keypad scanner result register
// Holds one result beat; frees itself in the cycle the beat is taken.
// ---------------------------------------------------------------------------
module kpd_out_reg
   import kpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   input  logic    out_stall,
   output logic    busy,
   output logic    out_valid,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // full and not drained this cycle
   assign busy     = valid_ff && out_stall;
   assign valid_in = load || busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Keypad scanner regression bench
// Sends command beats to the 4x4 keypad scanner: scan ticks with column
// levels, layout toggles and layout sets. The sender runs in random bursts
// with random gaps and the result side stalls on a pattern of its own. A scan
// predictor in the bench tracks row, column, settle count, held key and
// layout, and every result beat is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
   import kpd_pkg::*;

   // command code with no enum member; the scanner must ignore it
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // cycles with no beat moving on either side before the run is called hung
   localparam int         IDLE_LIMIT = 400;
   // stop printing mismatch lines after this many
   localparam int         PRINT_CAP  = 40;
   localparam logic [6:0] LETTER_A   = 7'h41;

   // digit layout, row major
   localparam logic [7:0] DIGIT_PAD [16] = '{
      "7", "8", "9", "/",
      "4", "5", "6", "*",
      "1", "2", "3", "-",
      "#", "0", "=", "+"
   };

   // one command beat waiting to be sent; drain holds it until all results are in
   typedef struct packed {
      logic [1:0] command;
      logic [3:0] cols;
      logic       layout;
      logic       drain;
   } cmd_beat_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [1:0]    req_command = CMD_TICK;
   logic [3:0]    req_column_levels = 4'hF;
   logic          req_layout_value = 1'b0;

   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [3:0]    rsp_row_drive;
   logic          rsp_key_valid;
   logic [6:0]    rsp_key_code;
   logic          rsp_layout_now;

   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_DEBOUNCE;
   logic [15:0]   csr_wdata = 16'd0;

   // scan predictor state and its copy of the registers
   logic [15:0]   cfg_debounce = DEBOUNCE_RESET;
   logic          layout_sel = LAYOUT_RESET;
   logic [1:0]    scan_row = 2'd0;
   logic [1:0]    scan_col = 2'd0;
   logic          release_wait = 1'b0;
   logic [15:0]   settle_ticks = 16'd0;
   logic [6:0]    latched_key = 7'd0;

   cmd_beat_type  cmd_backlog [$];
   rsp_type       rsp_due [$];

   int            beats_queued = 0;
   int            beats_taken = 0;
   int            fail_count = 0;
   int            idle_cycles = 0;
   int            burst_left = 1;
   int            gap_left = 0;
   int            stall_left = 0;
   int            free_left = 0;

   matrix_keypad_scanner uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_column_levels (req_column_levels),
      .req_layout_value  (req_layout_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_row_drive     (rsp_row_drive),
      .rsp_key_valid     (rsp_key_valid),
      .rsp_key_code      (rsp_key_code),
      .rsp_layout_now    (rsp_layout_now),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Advance the scan to the next column, wrapping into the next row.
   function automatic void step_column();
      if (scan_col == 2'd3) begin
         scan_col = 2'd0;
         scan_row = scan_row + 2'd1;
      end else begin
         scan_col = scan_col + 2'd1;
      end
      settle_ticks = 16'd0;
   endfunction

   // Apply one command beat to the predictor and return the result beat it causes.
   function automatic rsp_type scan_step(input logic [1:0] command, input logic [3:0] cols,
                                         input logic lay);
      rsp_type r;
      logic    col_up;
      r = '0;
      col_up = cols[scan_col];
      case (command)
         CMD_TICK: begin
            if (release_wait) begin
               // key is held: emit on the first tick that sees the column high
               if (col_up) begin
                  r.key_valid = 1'b1;
                  r.key_code = latched_key;
                  release_wait = 1'b0;
                  step_column();
               end
            end else if (settle_ticks < cfg_debounce) begin
               settle_ticks = settle_ticks + 16'd1;
            end else if (!col_up) begin
               // latch with the layout in force now; later layout changes keep it
               latched_key = layout_sel ? LETTER_A + 7'({scan_row, scan_col})
                                        : DIGIT_PAD[{scan_row, scan_col}][6:0];
               release_wait = 1'b1;
            end else begin
               step_column();
            end
         end
         CMD_TOGGLE: begin
            layout_sel = ~layout_sel;
         end
         CMD_SET: begin
            layout_sel = lay;
         end
         default: begin
            // unused code: no state change, plain result beat
         end
      endcase
      r.row_drive = ~(4'b0001 << scan_row);
      r.layout_now = layout_sel;
      return r;
   endfunction

   task automatic report_field(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      end
   endtask

   task automatic add_beat(input logic [1:0] command, input logic [3:0] cols,
                           input logic lay, input logic drain);
      cmd_backlog.push_back('{command: command, cols: cols, layout: lay, drain: drain});
      beats_queued++;
   endtask

   task automatic add_layout_change();
      add_beat($urandom_range(0, 1) ? CMD_TOGGLE : CMD_SET, 4'($urandom), 1'($urandom), 1'b0);
   endtask

   // Write one register; the block is idle whenever this is called.
   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      // the initial-layout register only loads at reset, so the live layout stays
      if (idx == CSR_DEBOUNCE) begin
         cfg_debounce = val;
      end
   endtask

   // Hold until every queued beat is taken and every result beat has come back.
   task automatic drain_wait();
      do begin
         @(negedge clock);
      end while (beats_taken != beats_queued || rsp_due.size() != 0);
   endtask

   // Mostly well-formed key presses: one column held low long enough for the scan
   // to reach it, then released; layout changes fall inside some holds. The rest
   // is an idle keypad, noisy column levels, layout commands and the unused code.
   task automatic random_traffic(input int count);
      int         added;
      int         span;
      int         pick;
      int         hold;
      logic [3:0] mask;
      added = 0;
      span = (cfg_debounce > 16'd12) ? 13 : int'(cfg_debounce) + 1;
      while (added < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            mask = ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                : ~(4'b0001 << $urandom_range(0, 3));
            hold = $urandom_range(1, 5 * span);
            repeat (hold) begin
               if ($urandom_range(0, 11) == 0) begin
                  add_layout_change();
                  added++;
               end
               add_beat(CMD_TICK, mask, 1'($urandom), $urandom_range(0, 199) == 0);
               added++;
            end
            repeat ($urandom_range(1, 2 * span)) begin
               add_beat(CMD_TICK, 4'hF, 1'($urandom), 1'b0);
               added++;
            end
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 3 * span)) begin
               add_beat(CMD_TICK, 4'hF, 1'($urandom), 1'b0);
               added++;
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) begin
               add_beat(CMD_TICK, 4'($urandom), 1'($urandom), 1'b0);
               added++;
            end
         end else if (pick < 97) begin
            add_layout_change();
            added++;
         end else begin
            add_beat(CMD_UNUSED, 4'($urandom), 1'($urandom), 1'b0);
            added++;
         end
      end
   endtask

   // Sender: predict each beat as it is taken, then present the next one from the
   // backlog in bursts with gaps. A taken beat that is followed at once by another
   // keeps valid high with a single assignment this step.
   always @(posedge clock) begin : command_drive
      cmd_beat_type nxt;
      logic         show;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         show = req_valid;
         if (req_valid && !req_stall) begin
            rsp_due.push_back(scan_step(req_command, req_column_levels, req_layout_value));
            beats_taken++;
            show = 1'b0;
         end
         if (!show) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain && rsp_due.size() != 0)) begin
               nxt = cmd_backlog.pop_front();
               req_command <= nxt.command;
               req_column_levels <= nxt.cols;
               req_layout_value <= nxt.layout;
               show = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // new burst: now and then a long one with no gaps at all
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 12);
                  gap_left = $urandom_range(1, 8);
               end
            end
         end
         req_valid <= show;
      end
   end

   // Receiver: stall on its own run-length pattern and check every taken beat.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               report_field("result beat with nothing expected", 1, 0);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_row_drive !== want.row_drive) begin
                  report_field("row_drive", rsp_row_drive, want.row_drive);
               end
               if (rsp_key_valid !== want.key_valid) begin
                  report_field("key_valid", rsp_key_valid, want.key_valid);
               end
               if (rsp_key_code !== want.key_code) begin
                  report_field("key_code", rsp_key_code, want.key_code);
               end
               if (rsp_layout_now !== want.layout_now) begin
                  report_field("layout_now", rsp_layout_now, want.layout_now);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            stall_left = $urandom_range(1, 5);
            free_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 6);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: count cycles in which no beat moves on either channel.
   always @(posedge clock) begin : hang_watch
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("matrix_keypad_scanner regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: sample on every tick, walk the whole matrix once.
      write_csr(CSR_DEBOUNCE, 16'd0);
      write_csr(CSR_INIT_LAYOUT, 16'd1);   // layout must not move: reset-only register
      add_beat(CMD_TICK, 4'h0, 1'b0, 1'b0);     // all columns low: latch top-left digit
      add_beat(CMD_TICK, 4'hF, 1'b1, 1'b0);     // release: emit it, advance
      add_beat(CMD_TOGGLE, 4'h0, 1'b0, 1'b0);   // switch to letters
      add_beat(CMD_TICK, 4'hF, 1'b0, 1'b0);
      add_beat(CMD_TICK, 4'hF, 1'b0, 1'b0);
      add_beat(CMD_TICK, 4'hE, 1'b0, 1'b0);     // only column 3 matters here: pass, wrap row
      add_beat(CMD_TICK, 4'h7, 1'b0, 1'b0);     // column 0 high: pass
      repeat (10) add_beat(CMD_TICK, 4'hF, 1'b0, 1'b0);
      add_beat(CMD_TICK, 4'h7, 1'b1, 1'b0);     // bottom-right low: latch last letter
      add_beat(CMD_SET, 4'hF, 1'b0, 1'b0);      // layout change while the key is held
      add_beat(CMD_TICK, 4'h0, 1'b0, 1'b0);     // still held
      add_beat(CMD_TICK, 4'h8, 1'b0, 1'b0);     // release: emit, wrap back to row 0
      add_beat(CMD_UNUSED, 4'h0, 1'b1, 1'b0);
      add_beat(CMD_SET, 4'h5, 1'b1, 1'b1);      // hold the sender until all results are in
      add_beat(CMD_TOGGLE, 4'hA, 1'b1, 1'b0);
      drain_wait();

      // Random part, one debounce setting per phase.
      write_csr(CSR_DEBOUNCE, DEBOUNCE_RESET);
      random_traffic(150);
      drain_wait();
      write_csr(CSR_DEBOUNCE, 16'hFFFF);   // longest settle: every tick just counts
      random_traffic(40);
      drain_wait();
      write_csr(CSR_DEBOUNCE, 16'd1);
      write_csr(CSR_INIT_LAYOUT, 16'd0);
      random_traffic(250);
      drain_wait();
      write_csr(CSR_DEBOUNCE, 16'd3);
      random_traffic(250);
      drain_wait();
      write_csr(CSR_DEBOUNCE, 16'd0);
      random_traffic(250);
      drain_wait();

      // let any stray result beat show up before the verdict
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("matrix_keypad_scanner regression: pass");
      end else begin
         $display("matrix_keypad_scanner regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/kpd_pkg.sv
rtl/core/kpd_core.sv
rtl/core/kpd_out_reg.sv
rtl/core/matrix_keypad_scanner.sv
test/tb_top.sv
